>>> rtl/dead_reckoning_pose_integrator_top_macros.svh
// ----------------------------------------------------------------------------
// Assertion macros for the pose integrator checker
// ----------------------------------------------------------------------------
`ifndef DEAD_RECKONING_POSE_INTEGRATOR_TOP_MACROS_SVH
`define DEAD_RECKONING_POSE_INTEGRATOR_TOP_MACROS_SVH

// same-cycle implication, reset masked
`define DRPI_ASSERT_NOW(label, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("drpi assertion failed");

// next-cycle implication, reset masked
`define DRPI_ASSERT_NEXT(label, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("drpi assertion failed");

`endif

>>> rtl/drpi_pkg.sv
// ----------------------------------------------------------------------------
// drpi_pkg
// Types, constants and the arctangent table of the pose integrator.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
package drpi_pkg;

  localparam int CORDIC_STEPS   = 16;
  localparam int ITER_W         = $clog2(CORDIC_STEPS);
  localparam int MAX_ELAPSED_MS = 1000;

  localparam logic [21:0] DEADBAND_RESET = 22'd2288;
  localparam logic signed [24:0] PI_Q16     = 25'sd205887;
  localparam logic signed [24:0] TWO_PI_Q16 = 25'sd411775;
  localparam logic signed [33:0] PI_Q30      = 34'sd3373259426;
  localparam logic signed [33:0] HALF_PI_Q30 = 34'sd1686629713;
  localparam logic signed [32:0] GAIN_Q30    = 33'sd652032874;
  // ceil(2^36 / 125): exact floor division for operands below 2^29
  localparam logic signed [32:0] RECIP_125   = 33'sd549755814;
  localparam logic signed [48:0] POS_MAX = 49'sd140737488355327;
  localparam logic signed [48:0] POS_MIN = -49'sd140737488355328;

  localparam logic [3:0] OP_NONE   = 4'd0;
  localparam logic [3:0] OP_LOAD   = 4'd1;
  localparam logic [3:0] OP_MUL_D  = 4'd2;
  localparam logic [3:0] OP_MUL_H  = 4'd3;
  localparam logic [3:0] OP_DIV1_H = 4'd4;
  localparam logic [3:0] OP_DIV2_H = 4'd5;
  localparam logic [3:0] OP_WRAP   = 4'd6;
  localparam logic [3:0] OP_CINIT  = 4'd7;
  localparam logic [3:0] OP_CITER  = 4'd8;
  localparam logic [3:0] OP_CFIN   = 4'd9;
  localparam logic [3:0] OP_MUL_X  = 4'd10;
  localparam logic [3:0] OP_MUL_Y  = 4'd11;
  localparam logic [3:0] OP_DIV1_P = 4'd12;
  localparam logic [3:0] OP_DIV2_X = 4'd13;
  localparam logic [3:0] OP_DIV2_Y = 4'd14;
  localparam logic [3:0] OP_PUB    = 4'd15;

  typedef struct packed {
    logic [3:0]        op;
    logic [ITER_W-1:0] iter;
  } cmd_t;

  typedef struct packed {
    logic wrap_ok;
  } status_t;

  function automatic logic [31:0] atan_q30(input logic [4:0] i);
    logic [31:0] v;
    case (i)
      5'd0:  v = 32'h3243F6A8;
      5'd1:  v = 32'h1DAC6705;
      5'd2:  v = 32'h0FADBAFC;
      5'd3:  v = 32'h07F56EA6;
      5'd4:  v = 32'h03FEAB76;
      5'd5:  v = 32'h01FFD55B;
      5'd6:  v = 32'h00FFFAAA;
      5'd7:  v = 32'h007FFF55;
      5'd8:  v = 32'h003FFFEA;
      5'd9:  v = 32'h001FFFFD;
      5'd10: v = 32'h000FFFFF;
      5'd11: v = 32'h0007FFFF;
      5'd12: v = 32'h0003FFFF;
      5'd13: v = 32'h0001FFFF;
      5'd14: v = 32'h0000FFFF;
      5'd15: v = 32'h00007FFF;
      5'd16: v = 32'h00003FFF;
      5'd17: v = 32'h00001FFF;
      5'd18: v = 32'h00000FFF;
      5'd19: v = 32'h000007FF;
      5'd20: v = 32'h000003FF;
      5'd21: v = 32'h000001FF;
      5'd22: v = 32'h000000FF;
      5'd23: v = 32'h0000007F;
      default: v = 32'h0;
    endcase
    return v;
  endfunction

endpackage

>>> rtl/drpi_dp.sv
// ----------------------------------------------------------------------------
// drpi_dp
// Datapath: shared multiplier, reciprocal divide, heading wrap, CORDIC, pose.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
module drpi_dp (
  input  logic                 clk,
  input  logic                 rst_n,
  input  drpi_pkg::cmd_t       cmd,
  output drpi_pkg::status_t    status,
  input  logic signed [19:0]   in_linear_speed,
  input  logic signed [21:0]   in_yaw_rate,
  input  logic [9:0]           in_elapsed_ms,
  input  logic                 cfg_wr_en,
  input  logic [21:0]          cfg_wr_data,
  output logic signed [47:0]   out_pos_x,
  output logic signed [47:0]   out_pos_y,
  output logic signed [18:0]   out_heading_out
);
  import drpi_pkg::*;

  logic [21:0]        db_r;
  logic signed [19:0] spd_r;
  logic signed [21:0] rate_r;
  logic [9:0]         ms_r;
  logic               integ_r;
  logic signed [63:0] prod_r;
  logic               neg_r;
  logic signed [30:0] dist_r;
  logic signed [24:0] wrap_r;
  logic signed [18:0] head_r;
  logic signed [32:0] cx_r, cy_r, c_r, s_r;
  logic signed [33:0] cz_r;
  logic               fold_r;
  logic signed [47:0] px_r, py_r;
  logic signed [47:0] ox_r, oy_r;
  logic signed [18:0] oh_r;

  logic signed [32:0] mul_a, mul_b;
  logic signed [65:0] mul_full;
  logic [63:0]        prod_abs, sum_h, sum_p;
  logic [28:0]        n_div;
  logic [23:0]        q_abs;
  logic signed [24:0] q_s, h_sum;
  logic signed [48:0] sum_x, sum_y;
  logic [21:0]        rate_abs;
  logic signed [33:0] z0;
  logic signed [32:0] xs, ys;
  logic [31:0]        at;

  assign rate_abs = in_yaw_rate[21] ? 22'(-in_yaw_rate) : 22'(in_yaw_rate);
  assign prod_abs = prod_r[63] ? 64'(-prod_r) : 64'(prod_r);
  assign sum_h    = prod_abs + 64'd500;
  assign sum_p    = prod_abs + (64'd500 << 30);
  // round-half-away then /8 before the /125 reciprocal step
  assign n_div    = (cmd.op == OP_DIV1_H) ? sum_h[31:3] : sum_p[61:33];
  assign q_abs    = prod_r[59:36];
  assign q_s      = neg_r ? -$signed({1'b0, q_abs}) : $signed({1'b0, q_abs});
  assign h_sum    = {{6{head_r[18]}}, head_r} + (integ_r ? q_s : 25'sd0);
  assign sum_x    = {px_r[47], px_r} + {{24{q_s[24]}}, q_s};
  assign sum_y    = {py_r[47], py_r} + {{24{q_s[24]}}, q_s};
  assign status.wrap_ok = !wrap_r[24] && (wrap_r < TWO_PI_Q16);

  assign z0 = {{15{head_r[18]}}, head_r} <<< 14;
  assign xs = cx_r >>> cmd.iter;
  assign ys = cy_r >>> cmd.iter;
  assign at = atan_q30(5'(cmd.iter));

  always_comb begin
    mul_a = '0;
    mul_b = '0;
    case (cmd.op)
      OP_MUL_D: begin
        mul_a = {{13{spd_r[19]}}, spd_r};
        mul_b = {23'd0, ms_r};
      end
      OP_MUL_H: begin
        mul_a = {{11{rate_r[21]}}, rate_r};
        mul_b = {23'd0, ms_r};
      end
      OP_DIV1_H, OP_DIV1_P: begin
        mul_a = {4'd0, n_div};
        mul_b = RECIP_125;
      end
      OP_MUL_X: begin
        mul_a = {{2{dist_r[30]}}, dist_r};
        mul_b = c_r;
      end
      OP_MUL_Y: begin
        mul_a = {{2{dist_r[30]}}, dist_r};
        mul_b = s_r;
      end
      default: ;
    endcase
  end

  assign mul_full = mul_a * mul_b;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      db_r   <= DEADBAND_RESET;
      head_r <= '0;
      px_r   <= '0;
      py_r   <= '0;
    end else begin
      if (cfg_wr_en) begin
        db_r <= cfg_wr_data;
      end
      case (cmd.op)
        OP_WRAP: if (status.wrap_ok) begin
          head_r <= 19'(wrap_r - PI_Q16);
        end
        OP_DIV2_X: px_r <= (sum_x > POS_MAX) ? 48'(POS_MAX) :
                           (sum_x < POS_MIN) ? 48'(POS_MIN) : sum_x[47:0];
        OP_DIV2_Y: py_r <= (sum_y > POS_MAX) ? 48'(POS_MAX) :
                           (sum_y < POS_MIN) ? 48'(POS_MIN) : sum_y[47:0];
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    prod_r <= mul_full[63:0];
    case (cmd.op)
      OP_LOAD: begin
        spd_r   <= in_linear_speed;
        rate_r  <= in_yaw_rate;
        ms_r    <= (in_elapsed_ms > 10'(MAX_ELAPSED_MS)) ? 10'(MAX_ELAPSED_MS)
                                                          : in_elapsed_ms;
        integ_r <= rate_abs > db_r;
      end
      OP_MUL_H:  dist_r <= prod_r[30:0];
      OP_DIV1_H, OP_DIV1_P: neg_r <= prod_r[63];
      OP_DIV2_H: wrap_r <= h_sum + PI_Q16;
      OP_WRAP: begin
        if (wrap_r[24]) begin
          wrap_r <= wrap_r + TWO_PI_Q16;
        end else if (!status.wrap_ok) begin
          wrap_r <= wrap_r - TWO_PI_Q16;
        end
      end
      OP_CINIT: begin
        cx_r <= GAIN_Q30;
        cy_r <= '0;
        if (z0 > HALF_PI_Q30) begin
          cz_r   <= z0 - PI_Q30;
          fold_r <= 1'b1;
        end else if (z0 < -HALF_PI_Q30) begin
          cz_r   <= z0 + PI_Q30;
          fold_r <= 1'b1;
        end else begin
          cz_r   <= z0;
          fold_r <= 1'b0;
        end
      end
      OP_CITER: begin
        if (!cz_r[33]) begin
          cx_r <= cx_r - ys;
          cy_r <= cy_r + xs;
          cz_r <= cz_r - $signed({2'b00, at});
        end else begin
          cx_r <= cx_r + ys;
          cy_r <= cy_r - xs;
          cz_r <= cz_r + $signed({2'b00, at});
        end
      end
      OP_CFIN: begin
        c_r <= fold_r ? -cx_r : cx_r;
        s_r <= fold_r ? -cy_r : cy_r;
      end
      OP_PUB: begin
        ox_r <= px_r;
        oy_r <= py_r;
        oh_r <= head_r;
      end
      default: ;
    endcase
  end

  assign out_pos_x       = ox_r;
  assign out_pos_y       = oy_r;
  assign out_heading_out = oh_r;

endmodule

>>> rtl/drpi_ctrl.sv
// ----------------------------------------------------------------------------
// drpi_ctrl
// Sequencer: steps the datapath through one update and owns the handshakes.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
module drpi_ctrl (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              in_valid,
  output logic              in_ready,
  output logic              out_valid,
  input  logic              out_ready,
  input  drpi_pkg::status_t status,
  output drpi_pkg::cmd_t    cmd
);
  import drpi_pkg::*;

  localparam logic [3:0] ST_IDLE   = 4'd0;
  localparam logic [3:0] ST_MUL_D  = 4'd1;
  localparam logic [3:0] ST_MUL_H  = 4'd2;
  localparam logic [3:0] ST_DIV1_H = 4'd3;
  localparam logic [3:0] ST_DIV2_H = 4'd4;
  localparam logic [3:0] ST_WRAP   = 4'd5;
  localparam logic [3:0] ST_CINIT  = 4'd6;
  localparam logic [3:0] ST_CITER  = 4'd7;
  localparam logic [3:0] ST_CFIN   = 4'd8;
  localparam logic [3:0] ST_MUL_X  = 4'd9;
  localparam logic [3:0] ST_DIV1_X = 4'd10;
  localparam logic [3:0] ST_DIV2_X = 4'd11;
  localparam logic [3:0] ST_MUL_Y  = 4'd12;
  localparam logic [3:0] ST_DIV1_Y = 4'd13;
  localparam logic [3:0] ST_DIV2_Y = 4'd14;
  localparam logic [3:0] ST_DONE   = 4'd15;

  logic [3:0]        state_r, state_nxt;
  logic [ITER_W-1:0] iter_r, iter_nxt;
  logic              ov_r, ov_nxt;
  logic              pub;

  assign in_ready  = (state_r == ST_IDLE);
  assign out_valid = ov_r;
  assign pub       = (state_r == ST_DONE) && (!ov_r || out_ready);

  always_comb begin
    state_nxt = state_r;
    iter_nxt  = iter_r;
    ov_nxt    = pub ? 1'b1 : (out_ready ? 1'b0 : ov_r);
    cmd.op    = OP_NONE;
    cmd.iter  = iter_r;
    unique case (state_r)
      ST_IDLE: if (in_valid) begin
        cmd.op    = OP_LOAD;
        state_nxt = ST_MUL_D;
      end
      ST_MUL_D:  begin cmd.op = OP_MUL_D;  state_nxt = ST_MUL_H;  end
      ST_MUL_H:  begin cmd.op = OP_MUL_H;  state_nxt = ST_DIV1_H; end
      ST_DIV1_H: begin cmd.op = OP_DIV1_H; state_nxt = ST_DIV2_H; end
      ST_DIV2_H: begin cmd.op = OP_DIV2_H; state_nxt = ST_WRAP;   end
      ST_WRAP: begin
        cmd.op = OP_WRAP;
        if (status.wrap_ok) begin
          state_nxt = ST_CINIT;
        end
      end
      ST_CINIT: begin
        cmd.op    = OP_CINIT;
        iter_nxt  = '0;
        state_nxt = ST_CITER;
      end
      ST_CITER: begin
        cmd.op   = OP_CITER;
        iter_nxt = iter_r + 1'b1;
        if (iter_r == ITER_W'(CORDIC_STEPS - 1)) begin
          state_nxt = ST_CFIN;
        end
      end
      ST_CFIN:   begin cmd.op = OP_CFIN;   state_nxt = ST_MUL_X;  end
      ST_MUL_X:  begin cmd.op = OP_MUL_X;  state_nxt = ST_DIV1_X; end
      ST_DIV1_X: begin cmd.op = OP_DIV1_P; state_nxt = ST_DIV2_X; end
      ST_DIV2_X: begin cmd.op = OP_DIV2_X; state_nxt = ST_MUL_Y;  end
      ST_MUL_Y:  begin cmd.op = OP_MUL_Y;  state_nxt = ST_DIV1_Y; end
      ST_DIV1_Y: begin cmd.op = OP_DIV1_P; state_nxt = ST_DIV2_Y; end
      ST_DIV2_Y: begin cmd.op = OP_DIV2_Y; state_nxt = ST_DONE;   end
      ST_DONE: if (pub) begin
        cmd.op    = OP_PUB;
        state_nxt = ST_IDLE;
      end
      default: state_nxt = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= ST_IDLE;
      iter_r  <= '0;
      ov_r    <= 1'b0;
    end else begin
      state_r <= state_nxt;
      iter_r  <= iter_nxt;
      ov_r    <= ov_nxt;
    end
  end

endmodule

>>> rtl/dead_reckoning_pose_integrator_top.sv
// ----------------------------------------------------------------------------
// dead_reckoning_pose_integrator_top
// Odometry pose integrator: heading, CORDIC cos/sin, saturating x/y update.
// ----------------------------------------------------------------------------
// channel | ports                                   | handshake
// input   | in_linear_speed, in_yaw_rate, in_elapsed_ms | in_valid / in_ready
// result  | out_pos_x, out_pos_y, out_heading_out   | out_valid / out_ready
// config  | cfg_wr_data                             | cfg_wr_en
//
// A result is published after 4 multiply/divide steps for the heading,
// 1 to 7 heading wrap steps, the CORDIC init, iteration and finish steps,
// the multiply and divide steps for x and y and a publish step. The
// sequencer is back in idle when out_valid rises; a result waiting in
// the output register holds only the final publish step.
// Synchronous reset clears the pose and loads the deadband to 2 deg/s.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
module dead_reckoning_pose_integrator_top (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                in_valid,
  output logic                in_ready,
  input  logic signed [19:0]  in_linear_speed,
  input  logic signed [21:0]  in_yaw_rate,
  input  logic [9:0]          in_elapsed_ms,
  output logic                out_valid,
  input  logic                out_ready,
  output logic signed [47:0]  out_pos_x,
  output logic signed [47:0]  out_pos_y,
  output logic signed [18:0]  out_heading_out,
  input  logic                cfg_wr_en,
  input  logic [21:0]         cfg_wr_data
);
  import drpi_pkg::*;

  cmd_t    cmd;
  status_t status;

  drpi_ctrl u_ctrl (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_ready  (in_ready),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .status    (status),
    .cmd       (cmd)
  );

  drpi_dp u_dp (
    .clk             (clk),
    .rst_n           (rst_n),
    .cmd             (cmd),
    .status          (status),
    .in_linear_speed (in_linear_speed),
    .in_yaw_rate     (in_yaw_rate),
    .in_elapsed_ms   (in_elapsed_ms),
    .cfg_wr_en       (cfg_wr_en),
    .cfg_wr_data     (cfg_wr_data),
    .out_pos_x       (out_pos_x),
    .out_pos_y       (out_pos_y),
    .out_heading_out (out_heading_out)
  );

endmodule

>>> rtl/drpi_checker.sv
// ----------------------------------------------------------------------------
// drpi_checker
// Port-level checks on the pose integrator, bound to the top level.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`include "dead_reckoning_pose_integrator_top_macros.svh"
module drpi_checker (
  input logic               clk,
  input logic               rst_n,
  input logic               in_valid,
  input logic               in_ready,
  input logic               out_valid,
  input logic               out_ready,
  input logic signed [47:0] out_pos_x,
  input logic signed [47:0] out_pos_y,
  input logic signed [18:0] out_heading_out
);

  // stalled result beat holds
  `DRPI_ASSERT_NEXT(a_out_hold, out_valid && !out_ready, out_valid && $stable(out_pos_x) && $stable(out_pos_y) && $stable(out_heading_out))

  // published heading always inside the wrapped range
  `DRPI_ASSERT_NOW(a_head_range, out_valid, (out_heading_out <= 19'sd205887) && (out_heading_out >= -19'sd205887))

  // one update at a time: busy straight after an accepted beat
  `DRPI_ASSERT_NEXT(a_busy, in_valid && in_ready, !in_ready)

endmodule

bind dead_reckoning_pose_integrator_top drpi_checker u_drpi_checker (
  .clk             (clk),
  .rst_n           (rst_n),
  .in_valid        (in_valid),
  .in_ready        (in_ready),
  .out_valid       (out_valid),
  .out_ready       (out_ready),
  .out_pos_x       (out_pos_x),
  .out_pos_y       (out_pos_y),
  .out_heading_out (out_heading_out)
);

>>> tb/tb_dead_reckoning_pose_integrator_top.sv
// ----------------------------------------------------------------------------
// tb_dead_reckoning_pose_integrator_top
// Drives odometry updates through the pose integrator and checks each pose
// against an in-bench model of the heading, CORDIC and x/y update or a typed
// expected pose, across several deadband settings and idle/stall patterns.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
module tb_dead_reckoning_pose_integrator_top;

  localparam longint HEAD_PI    = 205887;
  localparam longint HEAD_2PI   = 411775;
  localparam longint ANG_PI     = 64'sd3373259426;
  localparam longint ANG_HALFPI = 64'sd1686629713;
  localparam longint UNIT_GAIN  = 64'sd652032874;
  localparam longint XY_MAX     = 64'sd140737488355327;
  localparam longint XY_MIN     = -64'sd140737488355328;
  localparam int     N_STEPS    = 16;
  localparam int     MS_CAP     = 1000;

  typedef struct {
    logic signed [47:0] px;
    logic signed [47:0] py;
    logic signed [18:0] hd;
  } pose_t;

  typedef struct {
    int  speed;
    int  rate;
    int  ms;
    bit  typed;
    pose_t want;
  } row_t;

  logic               clk = 0;
  logic               rst_n = 0;
  logic               in_valid = 0;
  logic               in_ready;
  logic signed [19:0] in_linear_speed = '0;
  logic signed [21:0] in_yaw_rate = '0;
  logic [9:0]         in_elapsed_ms = '0;
  logic               out_valid;
  logic               out_ready = 0;
  logic signed [47:0] out_pos_x;
  logic signed [47:0] out_pos_y;
  logic signed [18:0] out_heading_out;
  logic               cfg_wr_en = 0;
  logic [21:0]        cfg_wr_data = '0;

  dead_reckoning_pose_integrator_top dut (
    .clk(clk), .rst_n(rst_n),
    .in_valid(in_valid), .in_ready(in_ready),
    .in_linear_speed(in_linear_speed), .in_yaw_rate(in_yaw_rate),
    .in_elapsed_ms(in_elapsed_ms),
    .out_valid(out_valid), .out_ready(out_ready),
    .out_pos_x(out_pos_x), .out_pos_y(out_pos_y), .out_heading_out(out_heading_out),
    .cfg_wr_en(cfg_wr_en), .cfg_wr_data(cfg_wr_data)
  );

  always begin
    #5 clk = 1;
    #5 clk = 0;
  end

  // model state
  longint deadband;
  longint pose_x, pose_y, pose_hd;

  pose_t pose_q[$];
  int    errors = 0;
  int    n_poses = 0;
  int    n_beats = 0;
  int    idle_pct = 0;
  int    stall_pct = 0;

  function automatic longint atan_step(int i);
    case (i)
      0: return 64'h3243F6A8;   1: return 64'h1DAC6705;   2: return 64'h0FADBAFC;
      3: return 64'h07F56EA6;   4: return 64'h03FEAB76;   5: return 64'h01FFD55B;
      6: return 64'h00FFFAAA;   7: return 64'h007FFF55;   8: return 64'h003FFFEA;
      9: return 64'h001FFFFD;  10: return 64'h000FFFFF;  11: return 64'h0007FFFF;
      12: return 64'h0003FFFF; 13: return 64'h0001FFFF;  14: return 64'h0000FFFF;
      default: return 64'h00007FFF;
    endcase
  endfunction

  function automatic longint round_div(longint p, longint d);
    longint a;
    longint q;
    a = (p < 0) ? -p : p;
    q = (a + d / 2) / d;
    return (p < 0) ? -q : q;
  endfunction

  function automatic longint clamp_xy(longint v);
    if (v > XY_MAX) return XY_MAX;
    if (v < XY_MIN) return XY_MIN;
    return v;
  endfunction

  // one update of the pose; returns the pose that should come out
  function automatic pose_t advance_pose(int speed, int rate, int ms_in);
    longint ms, h, m, z, x, y, xs, ys, travel;
    bit     flip;
    pose_t  p;
    ms = (ms_in > MS_CAP) ? MS_CAP : ms_in;
    if (((rate < 0) ? -rate : rate) > deadband) begin
      h = pose_hd + round_div(longint'(rate) * ms, 1000);
      m = (h + HEAD_PI) % HEAD_2PI;
      if (m < 0) m += HEAD_2PI;
      pose_hd = m - HEAD_PI;
    end
    z = pose_hd * 16384;
    x = UNIT_GAIN;
    y = 0;
    flip = 0;
    if (z > ANG_HALFPI) begin
      z -= ANG_PI; flip = 1;
    end else if (z < -ANG_HALFPI) begin
      z += ANG_PI; flip = 1;
    end
    for (int i = 0; i < N_STEPS; i++) begin
      xs = x >>> i;
      ys = y >>> i;
      if (z >= 0) begin
        x -= ys; y += xs; z -= atan_step(i);
      end else begin
        x += ys; y -= xs; z += atan_step(i);
      end
    end
    if (flip) begin
      x = -x; y = -y;
    end
    travel = longint'(speed) * ms;
    pose_x = clamp_xy(pose_x + round_div(travel * x, 64'sd1073741824000));
    pose_y = clamp_xy(pose_y + round_div(travel * y, 64'sd1073741824000));
    p.px = pose_x[47:0];
    p.py = pose_y[47:0];
    p.hd = pose_hd[18:0];
    return p;
  endfunction

  task automatic send_update(int speed, int rate, int ms, bit typed, pose_t want);
    pose_t              p;
    logic signed [19:0] spd_b;
    logic signed [21:0] rate_b;
    logic [9:0]         ms_b;
    spd_b  = speed[19:0];
    rate_b = rate[21:0];
    ms_b   = ms[9:0];
    while ($urandom_range(99) < idle_pct) begin
      in_valid <= 0;
      @(posedge clk);
    end
    in_valid        <= 1;
    in_linear_speed <= spd_b;
    in_yaw_rate     <= rate_b;
    in_elapsed_ms   <= ms_b;
    do @(posedge clk); while (!in_ready);
    // model sees the field bits as driven
    p = advance_pose(int'(spd_b), int'(rate_b), int'(ms_b));
    pose_q.push_back(typed ? want : p);
    n_beats++;
  endtask

  task automatic drain_and_write(logic [21:0] v);
    in_valid <= 0;
    while (pose_q.size() != 0) @(posedge clk);
    repeat (40) @(posedge clk);
    cfg_wr_en   <= 1;
    cfg_wr_data <= v;
    @(posedge clk);
    cfg_wr_en <= 0;
    deadband = v;
  endtask

  function automatic int rand_rate();
    case ($urandom_range(3))
      0: return $urandom_range(4194303) - 2097152;
      1: return int'(deadband) + $urandom_range(2) - 1;            // around deadband
      2: return -(int'(deadband) + $urandom_range(2) - 1);
      default: return $urandom_range(200000) - 100000;
    endcase
  endfunction

  always @(posedge clk) begin
    out_ready <= ($urandom_range(99) >= stall_pct);
  end

  always @(posedge clk) begin
    pose_t e;
    if (rst_n && out_valid && out_ready) begin
      n_poses++;
      if (pose_q.size() == 0) begin
        $display("%0t: pose beat with nothing expected: x=%0d y=%0d h=%0d", $time,
                 out_pos_x, out_pos_y, out_heading_out);
        errors++;
      end else begin
        e = pose_q.pop_front();
        if (out_pos_x !== e.px) begin
          $display("%0t: pos_x expected %0d got %0d", $time, e.px, out_pos_x);
          errors++;
        end
        if (out_pos_y !== e.py) begin
          $display("%0t: pos_y expected %0d got %0d", $time, e.py, out_pos_y);
          errors++;
        end
        if (out_heading_out !== e.hd) begin
          $display("%0t: heading expected %0d got %0d", $time, e.hd, out_heading_out);
          errors++;
        end
      end
    end
  end

  initial begin
    #20ms;
    $display("dead_reckoning_pose_integrator_top: mismatch");
    $finish;
  end

  initial begin
    row_t  dir[$];
    row_t  r;
    pose_t zero;
    int    idles[4]  = '{0, 78, 0, 25};
    int    stalls[4] = '{0, 0, 78, 25};
    logic [21:0] bands[4];
    zero = '{px: 0, py: 0, hd: 0};
    deadband = 2288;
    pose_x = 0; pose_y = 0; pose_hd = 0;

    // from reset: no motion, rate exactly at deadband keeps heading at zero
    dir.push_back('{0, 0, 0, 1, zero});
    dir.push_back('{0, 2288, 1000, 1, zero});
    dir.push_back('{0, -2288, 1000, 1, zero});
    dir.push_back('{-524288, 2097151, 0, 1, zero});      // zero interval
    dir.push_back('{65536, 0, 1000, 0, zero});
    dir.push_back('{524287, 0, 1023, 0, zero});           // long interval clamps
    dir.push_back('{-524288, 0, 1000, 0, zero});
    dir.push_back('{65536, 2289, 1000, 0, zero});
    dir.push_back('{65536, 2097151, 1000, 0, zero});      // wraps heading
    dir.push_back('{524287, 2097151, 1000, 0, zero});
    dir.push_back('{524287, -2097152, 1000, 0, zero});
    dir.push_back('{-524288, -2097152, 1023, 0, zero});
    dir.push_back('{100000, 102943, 1000, 0, zero});      // heading near +pi/2
    dir.push_back('{100000, 102944, 1000, 0, zero});
    dir.push_back('{100000, -411774, 1000, 0, zero});
    dir.push_back('{-1, -2097152, 512, 0, zero});
    dir.push_back('{1, 1, 1, 0, zero});

    repeat (4) @(posedge clk);
    rst_n <= 1;
    @(posedge clk);
    foreach (dir[i]) begin
      r = dir[i];
      send_update(r.speed, r.rate, r.ms, r.typed, r.want);
    end

    bands[0] = 22'd0;
    bands[1] = 22'd2097152;
    bands[2] = 22'($urandom_range(100000));
    bands[3] = 22'd2288;
    for (int ph = 0; ph < 4; ph++) begin
      drain_and_write(bands[ph]);
      idle_pct  = idles[ph];
      stall_pct = stalls[ph];
      for (int k = 0; k < 150; k++) begin
        send_update($urandom_range(1048575) - 524288, rand_rate(),
                    ($urandom_range(3) == 0) ? $urandom_range(1023) : $urandom_range(1000),
                    0, zero);
      end
    end

    in_valid <= 0;
    idle_pct = 0;
    stall_pct = 0;
    while (pose_q.size() != 0) @(posedge clk);
    repeat (60) @(posedge clk);
    $display("Sent %0d odometry beats, checked %0d poses over five deadband settings",
             n_beats, n_poses);
    $display("with idle and stall phases; %0d field errors", errors);
    if (errors == 0) begin
      $display("dead_reckoning_pose_integrator_top: match");
    end else begin
      $display("dead_reckoning_pose_integrator_top: mismatch");
    end
    $finish;
  end

endmodule

>>> files.f
+incdir+rtl
rtl/drpi_pkg.sv
rtl/drpi_dp.sv
rtl/drpi_ctrl.sv
rtl/dead_reckoning_pose_integrator_top.sv
rtl/drpi_checker.sv
tb/tb_dead_reckoning_pose_integrator_top.sv
